// File: hdl/triangle_classify_measure_defines.svh
// Assertion macros used by the checker file of the triangle classifier.
// Depends on nothing; expects clk_i and rst_ni in the scope of use.
`ifndef TRIANGLE_CLASSIFY_MEASURE_DEFINES_SVH
`define TRIANGLE_CLASSIFY_MEASURE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tcm_pkg.sv
// Shared types and field widths of the triangle classifier.
// Depends on nothing.
package tcm_pkg;

  localparam int unsigned TolW   = 16;
  localparam int unsigned AreaW  = 33;
  localparam int unsigned PerimW = 19;
  localparam int unsigned OutW   = 56;

  typedef struct packed {
    logic valid_tri;
    logic equi;
    logic isos;
    logic right;
  } flags_t;

endpackage

// File: hdl/tcm_front.sv
// Front pipeline: edge vectors, products, squared lengths and cross product,
// then classification flags and absolute area. Depends on tcm_pkg.
module tcm_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic [tcm_pkg::TolW-1:0]     tol_i,
  output logic                         valid_o,
  output tcm_pkg::flags_t              flags_o,
  output logic [2*COORD_BITS:0]        area_o,
  output logic [2*COORD_BITS:0]        sab_o,
  output logic [2*COORD_BITS:0]        sac_o,
  output logic [2*COORD_BITS:0]        sbc_o
);

  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned SQW = 2 * COORD_BITS + 1;
  localparam int unsigned PYW = SQW + 2;

  // Stage 1: edge vectors.
  logic [3:0] vld_q;
  logic signed [DW-1:0] abx_q, aby_q, acx_q, acy_q, bcx_q, bcy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abx_q <= DW'(bx_i) - DW'(ax_i);
      aby_q <= DW'(by_i) - DW'(ay_i);
      acx_q <= DW'(cx_i) - DW'(ax_i);
      acy_q <= DW'(cy_i) - DW'(ay_i);
      bcx_q <= DW'(cx_i) - DW'(bx_i);
      bcy_q <= DW'(cy_i) - DW'(by_i);
    end
  end

  // Stage 2: squares and the two cross terms.
  logic signed [PW-1:0] pabx_q, paby_q, pacx_q, pacy_q, pbcx_q, pbcy_q, pc1_q, pc2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pabx_q <= abx_q * abx_q;
      paby_q <= aby_q * aby_q;
      pacx_q <= acx_q * acx_q;
      pacy_q <= acy_q * acy_q;
      pbcx_q <= bcx_q * bcx_q;
      pbcy_q <= bcy_q * bcy_q;
      pc1_q  <= abx_q * acy_q;
      pc2_q  <= aby_q * acx_q;
    end
  end

  // Stage 3: squared lengths and cross product.
  logic [SQW-1:0]       sab_q, sac_q, sbc_q;
  logic signed [PW-1:0] cross_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sab_q   <= SQW'(pabx_q[SQW-2:0]) + SQW'(paby_q[SQW-2:0]);
      sac_q   <= SQW'(pacx_q[SQW-2:0]) + SQW'(pacy_q[SQW-2:0]);
      sbc_q   <= SQW'(pbcx_q[SQW-2:0]) + SQW'(pbcy_q[SQW-2:0]);
      cross_q <= pc1_q - pc2_q;
    end
  end

  // Stage 4: flags and area.
  logic signed [PYW-1:0] d1, d2, d3;
  logic [PYW-1:0]        m1, m2, m3;
  logic [PYW-1:0]        tol_ext;
  logic [PW-1:0]         cross_abs;
  tcm_pkg::flags_t       flags_d, flags_q;
  logic [SQW-1:0]        area_q, s4ab_q, s4ac_q, s4bc_q;

  always_comb begin
    d1      = $signed(PYW'(sab_q)) + $signed(PYW'(sbc_q)) - $signed(PYW'(sac_q));
    d2      = $signed(PYW'(sbc_q)) + $signed(PYW'(sac_q)) - $signed(PYW'(sab_q));
    d3      = $signed(PYW'(sac_q)) + $signed(PYW'(sab_q)) - $signed(PYW'(sbc_q));
    m1      = d1[PYW-1] ? PYW'(-d1) : PYW'(d1);
    m2      = d2[PYW-1] ? PYW'(-d2) : PYW'(d2);
    m3      = d3[PYW-1] ? PYW'(-d3) : PYW'(d3);
    tol_ext = PYW'(tol_i);
    cross_abs = cross_q[PW-1] ? PW'(-cross_q) : PW'(cross_q);
    flags_d.valid_tri = (cross_q != '0);
    flags_d.equi  = (sab_q == sac_q) && (sac_q == sbc_q);
    flags_d.isos  = (sab_q == sac_q) || (sac_q == sbc_q) || (sbc_q == sab_q);
    flags_d.right = (m1 <= tol_ext) || (m2 <= tol_ext) || (m3 <= tol_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_d;
      area_q  <= cross_abs[SQW-1:0];
      s4ab_q  <= sab_q;
      s4ac_q  <= sac_q;
      s4bc_q  <= sbc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign flags_o = flags_q;
  assign area_o  = area_q;
  assign sab_o   = s4ab_q;
  assign sac_o   = s4ac_q;
  assign sbc_o   = s4bc_q;

endmodule

// File: hdl/tcm_isqrt_step.sv
// One registered digit step of a restoring integer square root.
// Depends on nothing.
module tcm_isqrt_step #(
  parameter int unsigned RT_W = 17
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2*RT_W-1:0]   val_i,
  input  logic [RT_W+1:0]     rem_i,
  input  logic [RT_W-1:0]     root_i,
  output logic [2*RT_W-1:0]   val_o,
  output logic [RT_W+1:0]     rem_o,
  output logic [RT_W-1:0]     root_o
);

  logic [RT_W+1:0] rem_s, trial;
  logic            ge;
  logic [2*RT_W-1:0] val_q;
  logic [RT_W+1:0]   rem_q;
  logic [RT_W-1:0]   root_q;

  // The remainder never exceeds twice the partial root, so its top two
  // bits are zero before the shift.
  always_comb begin
    rem_s = {rem_i[RT_W-1:0], val_i[2*RT_W-1 -: 2]};
    trial = {root_i, 2'b01};
    ge    = (rem_s >= trial);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= {val_i[2*RT_W-3:0], 2'b00};
      rem_q  <= ge ? (rem_s - trial) : rem_s;
      root_q <= {root_i[RT_W-2:0], ge};
    end
  end

  assign val_o  = val_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// File: hdl/triangle_classify_measure.sv
// From input beat to output beat a triangle passes four front stages, one
// square-root step per bit of the root and one output stage.
// Throughput: one triangle per cycle; the whole pipeline advances unless the
// output register holds a beat that is not taken. Reset clears all valid bits
// and sets right_tolerance to zero.
// Depends on tcm_pkg, tcm_front and tcm_isqrt_step.
module triangle_classify_measure #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tcm_pkg::TolW-1:0]         cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // ax, ay, bx, by, cx, cy from bit 0 up, zero padded to whole bytes
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // valid_triangle, equilateral, isosceles, right_angled, area_value,
  // perimeter_value from bit 0 up
  output logic [tcm_pkg::OutW-1:0]         m_axis_tdata
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned SQW  = 2 * CB + 1;
  localparam int unsigned RT_W = CB + 1;
  localparam int unsigned PSW  = (RT_W + 2 > tcm_pkg::PerimW) ? RT_W + 2 : tcm_pkg::PerimW;
  localparam int unsigned ARW  = (SQW > tcm_pkg::AreaW) ? SQW : tcm_pkg::AreaW;

  logic en;
  logic [tcm_pkg::TolW-1:0] tol_q;
  logic out_valid_q;
  logic [tcm_pkg::OutW-1:0] out_data_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  logic            f_valid;
  tcm_pkg::flags_t f_flags;
  logic [SQW-1:0]  f_area, f_sab, f_sac, f_sbc;

  tcm_front #(.COORD_BITS(CB)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .ax_i    (s_axis_tdata[0*CB +: CB]),
    .ay_i    (s_axis_tdata[1*CB +: CB]),
    .bx_i    (s_axis_tdata[2*CB +: CB]),
    .by_i    (s_axis_tdata[3*CB +: CB]),
    .cx_i    (s_axis_tdata[4*CB +: CB]),
    .cy_i    (s_axis_tdata[5*CB +: CB]),
    .tol_i   (tol_q),
    .valid_o (f_valid),
    .flags_o (f_flags),
    .area_o  (f_area),
    .sab_o   (f_sab),
    .sac_o   (f_sac),
    .sbc_o   (f_sbc)
  );

  // Square-root pipeline: three lanes, one step per root bit.
  logic [2*RT_W-1:0] val_s  [0:RT_W][0:2];
  logic [RT_W+1:0]   rem_s  [0:RT_W][0:2];
  logic [RT_W-1:0]   root_s [0:RT_W][0:2];
  logic              vld_s  [0:RT_W];
  tcm_pkg::flags_t   flg_s  [0:RT_W];
  logic [SQW-1:0]    area_s [0:RT_W];

  assign val_s[0][0]  = (2*RT_W)'(f_sab);
  assign val_s[0][1]  = (2*RT_W)'(f_sac);
  assign val_s[0][2]  = (2*RT_W)'(f_sbc);
  assign vld_s[0]     = f_valid;
  assign flg_s[0]     = f_flags;
  assign area_s[0]    = f_area;

  for (genvar l = 0; l < 3; l++) begin : g_lane_init
    assign rem_s[0][l]  = '0;
    assign root_s[0][l] = '0;
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_step
    for (genvar l = 0; l < 3; l++) begin : g_lane
      tcm_isqrt_step #(.RT_W(RT_W)) u_step (
        .clk_i  (clk_i),
        .en_i   (en),
        .val_i  (val_s[k][l]),
        .rem_i  (rem_s[k][l]),
        .root_i (root_s[k][l]),
        .val_o  (val_s[k+1][l]),
        .rem_o  (rem_s[k+1][l]),
        .root_o (root_s[k+1][l])
      );
    end

    tcm_pkg::flags_t flg_q;
    logic [SQW-1:0]  area_q;
    logic            vld_q;

    always_ff @(posedge clk_i) begin
      if (en) begin
        flg_q  <= flg_s[k];
        area_q <= area_s[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld_s[k];
      end
    end

    assign flg_s[k+1]  = flg_q;
    assign area_s[k+1] = area_q;
    assign vld_s[k+1]  = vld_q;
  end

  // Output stage: perimeter sum and field packing.
  logic [PSW-1:0] perim_sum;
  logic [ARW-1:0] area_ext;
  logic [tcm_pkg::OutW-1:0] out_data_d;

  always_comb begin
    perim_sum = PSW'(root_s[RT_W][0]) + PSW'(root_s[RT_W][1]) + PSW'(root_s[RT_W][2]);
    area_ext  = ARW'(area_s[RT_W]);
    out_data_d = {perim_sum[tcm_pkg::PerimW-1:0], area_ext[tcm_pkg::AreaW-1:0],
                  flg_s[RT_W].right, flg_s[RT_W].isos, flg_s[RT_W].equi,
                  flg_s[RT_W].valid_tri};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_s[RT_W];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: hdl/tcm_checker.sv
// Port-level checker for the triangle classifier, bound to the top level.
// Depends on tcm_pkg and triangle_classify_measure_defines.svh.
`include "triangle_classify_measure_defines.svh"

module tcm_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [tcm_pkg::OutW-1:0] m_axis_tdata
);

  `TCM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
  `TCM_ASSERT_IMPLY(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without an output stall")
  `TCM_ASSERT_IMPLY(a_equi_isos, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[2], "equilateral without isosceles")
  `TCM_ASSERT_IMPLY(a_flat_area, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[36:4] == '0, "degenerate triangle with nonzero area")

endmodule

bind triangle_classify_measure tcm_checker u_tcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/testbench.sv
// Self-checking testbench for triangle_classify_measure: random and directed
// triangles, an in-bench predictor of flags, area and perimeter. Uses tcm_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordW = 16;
  localparam int InW = ((6 * CoordW + 7) / 8) * 8;
  localparam int IdleLimit = 2000;
  localparam int Latency = CoordW + 6;

  // Declared from the highest bit down, so valid_tri lands in bit 0.
  typedef struct packed {
    logic [tcm_pkg::PerimW-1:0] perim;
    logic [tcm_pkg::AreaW-1:0] area;
    logic right;
    logic isos;
    logic equi;
    logic valid_tri;
  } shape_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tcm_pkg::TolW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [tcm_pkg::OutW-1:0] m_axis_tdata;

  triangle_classify_measure #(.COORD_BITS(CoordW)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  logic [InW-1:0] pending_tri[$];
  shape_t expected_shapes[$];
  logic [15:0] tolerance = '0;
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic within_tol(input longint d);
    longint m;
    m = (d < 0) ? -d : d;
    return m <= longint'(tolerance);
  endfunction

  function automatic shape_t measure_triangle(input logic [InW-1:0] d);
    longint c[6];
    longint abx, aby, acx, acy, bcx, bcy, sab, sac, sbc, cr;
    shape_t s;
    for (int i = 0; i < 6; i++) c[i] = longint'($signed(d[i*CoordW +: CoordW]));
    abx = c[2] - c[0]; aby = c[3] - c[1];
    acx = c[4] - c[0]; acy = c[5] - c[1];
    bcx = c[4] - c[2]; bcy = c[5] - c[3];
    sab = abx * abx + aby * aby;
    sac = acx * acx + acy * acy;
    sbc = bcx * bcx + bcy * bcy;
    cr = abx * acy - aby * acx;
    s.valid_tri = cr != 0;
    s.equi = (sab == sac) && (sac == sbc);
    s.isos = (sab == sac) || (sac == sbc) || (sbc == sab);
    s.right = within_tol(sab + sbc - sac) || within_tol(sbc + sac - sab) ||
              within_tol(sac + sab - sbc);
    s.area = tcm_pkg::AreaW'((cr < 0) ? -cr : cr);
    s.perim = tcm_pkg::PerimW'(root_floor(sab) + root_floor(sac) + root_floor(sbc));
    return s;
  endfunction

  // Driver: one beat per handshake; each beat draws the idle cycles that
  // follow it, so a draw of zero sends the next beat back to back.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_shapes.push_back(measure_triangle(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_tri.size() > 0) begin
          s_axis_tdata <= pending_tri.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap <= $urandom_range(0, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor with random backpressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        shape_t g, w;
        g = shape_t'(m_axis_tdata);
        if (expected_shapes.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          w = expected_shapes.pop_front();
          if (g.valid_tri !== w.valid_tri) report("valid_triangle", g.valid_tri, w.valid_tri);
          if (g.equi !== w.equi) report("equilateral", g.equi, w.equi);
          if (g.isos !== w.isos) report("isosceles", g.isos, w.isos);
          if (g.right !== w.right) report("right_angled", g.right, w.right);
          if (g.area !== w.area) report("area_value", g.area, w.area);
          if (g.perim !== w.perim) report("perimeter_value", g.perim, w.perim);
        end
        recv_gap = $urandom_range(0, 3);
      end
      if (recv_gap > 0) begin
        m_axis_tready <= 1'b0;
        recv_gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [InW-1:0] pack_tri(input logic [15:0] ax, ay, bx, by, cx, cy);
    logic [InW-1:0] d;
    d = '0;
    d[0 +: 96] = {cy, cx, by, bx, ay, ax};
    return d;
  endfunction

  function automatic logic [15:0] rnd_coord(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 64)) - 32);
      2: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
      default: return 16'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic [InW-1:0] random_tri();
    int m;
    logic [15:0] ax, ay, dx, dy;
    m = $urandom_range(0, 9);
    ax = rnd_coord(m % 4);
    ay = rnd_coord(m % 4);
    dx = rnd_coord(1);
    dy = rnd_coord(1);
    case (m)
      4: return pack_tri(ax, ay, ax + dx, ay + dy, ax + (dx << 1), ay + (dy << 1)); // collinear
      5: return pack_tri(ax, ay, ax + dx, ay + dy, ax - dy, ay + dx);         // right
      6: return pack_tri(ax, ay, ax + dx, ay + dy, ax - dx, ay + dy);         // isosceles
      default: return pack_tri(ax, ay, rnd_coord(m % 4), rnd_coord(m % 4),
                               rnd_coord(m % 4), rnd_coord(m % 4));
    endcase
  endfunction

  task automatic run_phase(input logic [15:0] tol, input int count, input bit directed);
    while (expected_shapes.size() > 0 || pending_tri.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    cfg_wdata_i <= tol;
    cfg_we_i <= 1'b1;
    tolerance = tol;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (directed) begin
      pending_tri.push_back(pack_tri(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      pending_tri.push_back(pack_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                     16'h7fff, 16'h7fff));
      pending_tri.push_back(pack_tri(16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                                     16'h8000, 16'h7fff));
      pending_tri.push_back(pack_tri(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                                     16'h7fff, 16'h7fff));
      pending_tri.push_back(pack_tri(16'd0, 16'd0, 16'd48, 16'd0, 16'd0, 16'd64));
      pending_tri.push_back(pack_tri(16'd0, 16'd0, 16'd16, 16'd0, 16'd32, 16'd0));
      pending_tri.push_back(pack_tri(16'd0, 16'd0, 16'd16, 16'd16, 16'd16, 16'd16));
      pending_tri.push_back(pack_tri(16'd0, 16'd0, 16'd20, 16'd0, 16'd10, 16'd30));
      pending_tri.push_back(pack_tri(16'hffff, 16'hffff, 16'd1, 16'd1, 16'hffff, 16'd1));
      pending_tri.push_back(pack_tri(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'd0, 16'd0));
      pending_tri.push_back(pack_tri(16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 16'd3));
      pending_tri.push_back(pack_tri(16'd0, 16'd0, 16'd4, 16'd0, 16'd2, 16'd3));
    end
    repeat (count) pending_tri.push_back(random_tri());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(16'd0, 400, 1'b1);
    run_phase(16'hffff, 400, 1'b1);
    run_phase(16'd200, 400, 1'b0);
    run_phase(16'd4, 400, 1'b1);
    while (expected_shapes.size() > 0 || pending_tri.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
